### sv/tsavpd_pkg.sv
package tsavpd_pkg;

  localparam logic [7:0] SYNC_BYTE        = 8'h47;
  localparam logic [7:0] VIDEO_SID_LOW    = 8'hE0;
  localparam logic [7:0] VIDEO_SID_HIGH   = 8'hEF;
  localparam logic [7:0] AUDIO_SID_LOW    = 8'hC0;
  localparam logic [7:0] AUDIO_SID_HIGH   = 8'hDF;
  localparam logic [7:0] PRIVATE_1_SID    = 8'hBD;
  localparam logic [8:0] DEFAULT_SID_POS  = 9'd7;
  localparam logic [8:0] ADAPT_SID_BASE   = 9'd8;
  localparam logic [7:0] POS_PID_HIGH     = 8'd1;
  localparam logic [7:0] POS_PID_LOW      = 8'd2;
  localparam logic [7:0] POS_FLAGS        = 8'd3;
  localparam logic [7:0] POS_ADAPT_LEN    = 8'd4;
  localparam int         UNIT_START_BIT   = 6;
  localparam int         ADAPT_BIT        = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_beat_t;

  typedef struct packed {
    logic [12:0] video_pid;
    logic        video_found;
    logic [12:0] audio_pid;
    logic        audio_found;
    logic        audio_is_ac3;
  } result_t;

endpackage

### sv/tsavpd_out_buf.sv
module tsavpd_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tsavpd_pkg::result_t push_data,
  output logic                full,
  output logic                result_valid,
  input  logic                result_stall,
  output tsavpd_pkg::result_t result_data
);

  logic                skid_valid;
  tsavpd_pkg::result_t skid_data;
  logic                pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid && pop) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else if (push) begin
      if (!result_valid || pop) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      result_data <= skid_data;
    end else if (push) begin
      if (!result_valid || pop) begin
        result_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

### sv/ts_av_pid_detector_unit.sv
// The result is registered in the output buffer from the end_of_buffer beat.
// One byte per cycle while not stalled; the parser state updates on accepted beats.
// A two-entry output buffer lets bytes flow while a result waits to be taken.
// Reset (rst, synchronous) returns the parser to sync hunting and empties the
// output buffer; the same parser state is also cleared after every result.
module ts_av_pid_detector_unit #(
  parameter int PACKET_BYTES = 188
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  tsavpd_pkg::byte_beat_t byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output tsavpd_pkg::result_t    result_data
);

  localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);

  logic        in_packet, in_packet_next;
  logic [7:0]  byte_position, byte_position_next;
  logic        unit_start_flag, unit_start_flag_next;
  logic        adaptation_flag, adaptation_flag_next;
  logic [12:0] captured_pid, captured_pid_next;
  logic [8:0]  stream_id_position, stream_id_position_next;
  logic [12:0] found_video_pid, found_video_pid_next;
  logic        video_seen, video_seen_next;
  logic [12:0] found_audio_pid, found_audio_pid_next;
  logic        audio_seen, audio_seen_next;
  logic        ac3_flag, ac3_flag_next;

  logic                accept;
  logic                buf_full;
  logic                push;
  tsavpd_pkg::result_t push_data;
  logic [7:0]          pos_inc;
  logic [8:0]          sid_pos_eff;
  logic [7:0]          b;

  assign byte_stall = buf_full;
  assign accept     = byte_valid && !byte_stall;
  assign b          = byte_data.data_byte;
  assign pos_inc    = byte_position + 8'd1;

  always_comb begin
    in_packet_next          = in_packet;
    byte_position_next      = byte_position;
    unit_start_flag_next    = unit_start_flag;
    adaptation_flag_next    = adaptation_flag;
    captured_pid_next       = captured_pid;
    stream_id_position_next = stream_id_position;
    found_video_pid_next    = found_video_pid;
    video_seen_next         = video_seen;
    found_audio_pid_next    = found_audio_pid;
    audio_seen_next         = audio_seen;
    ac3_flag_next           = ac3_flag;
    sid_pos_eff             = stream_id_position;
    push                    = 1'b0;
    push_data               = '0;

    if (accept) begin
      if (!in_packet) begin
        if (b == tsavpd_pkg::SYNC_BYTE) begin
          in_packet_next          = 1'b1;
          byte_position_next      = '0;
          unit_start_flag_next    = 1'b0;
          adaptation_flag_next    = 1'b0;
          captured_pid_next       = '0;
          stream_id_position_next = tsavpd_pkg::DEFAULT_SID_POS;
        end
      end else begin
        byte_position_next = pos_inc;
        if (pos_inc == tsavpd_pkg::POS_PID_HIGH) begin
          unit_start_flag_next = b[tsavpd_pkg::UNIT_START_BIT];
          captured_pid_next    = {b[4:0], 8'h00};
        end else if (pos_inc == tsavpd_pkg::POS_PID_LOW) begin
          captured_pid_next = {captured_pid[12:8], b};
        end else if (pos_inc == tsavpd_pkg::POS_FLAGS) begin
          adaptation_flag_next = b[tsavpd_pkg::ADAPT_BIT];
        end else if (pos_inc == tsavpd_pkg::POS_ADAPT_LEN && adaptation_flag) begin
          sid_pos_eff             = tsavpd_pkg::ADAPT_SID_BASE + {1'b0, b};
          stream_id_position_next = sid_pos_eff;
        end

        if (pos_inc >= tsavpd_pkg::POS_ADAPT_LEN && {1'b0, pos_inc} == sid_pos_eff &&
            unit_start_flag && !(video_seen && audio_seen)) begin
          if (b >= tsavpd_pkg::VIDEO_SID_LOW && b <= tsavpd_pkg::VIDEO_SID_HIGH) begin
            found_video_pid_next = captured_pid;
            video_seen_next      = 1'b1;
          end else if (b >= tsavpd_pkg::AUDIO_SID_LOW &&
                       b <= tsavpd_pkg::AUDIO_SID_HIGH) begin
            found_audio_pid_next = captured_pid;
            audio_seen_next      = 1'b1;
            ac3_flag_next        = 1'b0;
          end else if (b == tsavpd_pkg::PRIVATE_1_SID) begin
            found_audio_pid_next = captured_pid;
            audio_seen_next      = 1'b1;
            ac3_flag_next        = 1'b1;
          end
        end

        if (pos_inc >= LAST_POS) begin
          in_packet_next = 1'b0;
        end
      end

      if (byte_data.end_of_buffer) begin
        push                   = 1'b1;
        push_data.video_pid    = video_seen_next ? found_video_pid_next : '0;
        push_data.video_found  = video_seen_next;
        push_data.audio_pid    = audio_seen_next ? found_audio_pid_next : '0;
        push_data.audio_found  = audio_seen_next;
        push_data.audio_is_ac3 = audio_seen_next && ac3_flag_next;

        in_packet_next          = 1'b0;
        byte_position_next      = '0;
        unit_start_flag_next    = 1'b0;
        adaptation_flag_next    = 1'b0;
        captured_pid_next       = '0;
        stream_id_position_next = tsavpd_pkg::DEFAULT_SID_POS;
        found_video_pid_next    = '0;
        video_seen_next         = 1'b0;
        found_audio_pid_next    = '0;
        audio_seen_next         = 1'b0;
        ac3_flag_next           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet          <= 1'b0;
      byte_position      <= '0;
      unit_start_flag    <= 1'b0;
      adaptation_flag    <= 1'b0;
      captured_pid       <= '0;
      stream_id_position <= tsavpd_pkg::DEFAULT_SID_POS;
      found_video_pid    <= '0;
      video_seen         <= 1'b0;
      found_audio_pid    <= '0;
      audio_seen         <= 1'b0;
      ac3_flag           <= 1'b0;
    end else begin
      in_packet          <= in_packet_next;
      byte_position      <= byte_position_next;
      unit_start_flag    <= unit_start_flag_next;
      adaptation_flag    <= adaptation_flag_next;
      captured_pid       <= captured_pid_next;
      stream_id_position <= stream_id_position_next;
      found_video_pid    <= found_video_pid_next;
      video_seen         <= video_seen_next;
      found_audio_pid    <= found_audio_pid_next;
      audio_seen         <= audio_seen_next;
      ac3_flag           <= ac3_flag_next;
    end
  end

  tsavpd_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

### dv/ts_av_pid_detector_unit_test.sv
module ts_av_pid_detector_unit_test;

  localparam int PKT_BYTES    = 188;
  localparam int CLK_PERIOD   = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 2_000_000;

  class pid_scoreboard;
    tsavpd_pkg::result_t expected_results[$];
    bit                  framing;
    logic [7:0]          pos;
    bit                  unit_start;
    bit                  adapt;
    logic [12:0]         pid;
    logic [8:0]          sid_pos;
    logic [12:0]         video_pid;
    bit                  video_seen;
    logic [12:0]         audio_pid;
    bit                  audio_seen;
    bit                  ac3;
    int                  errors = 0;
    int                  reported = 0;
    int                  checked = 0;
    int                  video_hits = 0;
    int                  audio_hits = 0;
    int                  ac3_hits = 0;

    function new();
      clear_parser();
    endfunction

    function void clear_parser();
      framing = 1'b0;
      pos = '0;
      unit_start = 1'b0;
      adapt = 1'b0;
      pid = '0;
      sid_pos = tsavpd_pkg::DEFAULT_SID_POS;
      video_pid = '0;
      video_seen = 1'b0;
      audio_pid = '0;
      audio_seen = 1'b0;
      ac3 = 1'b0;
    endfunction

    function void classify(logic [7:0] sid);
      if (sid >= tsavpd_pkg::VIDEO_SID_LOW && sid <= tsavpd_pkg::VIDEO_SID_HIGH) begin
        video_pid = pid;
        video_seen = 1'b1;
      end else if (sid >= tsavpd_pkg::AUDIO_SID_LOW &&
                   sid <= tsavpd_pkg::AUDIO_SID_HIGH) begin
        audio_pid = pid;
        audio_seen = 1'b1;
        ac3 = 1'b0;
      end else if (sid == tsavpd_pkg::PRIVATE_1_SID) begin
        audio_pid = pid;
        audio_seen = 1'b1;
        ac3 = 1'b1;
      end
    endfunction

    function void note_beat(tsavpd_pkg::byte_beat_t beat);
      tsavpd_pkg::result_t r;
      if (!framing) begin
        if (beat.data_byte == tsavpd_pkg::SYNC_BYTE) begin
          framing = 1'b1;
          pos = '0;
          unit_start = 1'b0;
          adapt = 1'b0;
          pid = '0;
          sid_pos = tsavpd_pkg::DEFAULT_SID_POS;
        end
      end else begin
        pos = pos + 8'd1;
        if (pos == tsavpd_pkg::POS_PID_HIGH) begin
          unit_start = beat.data_byte[tsavpd_pkg::UNIT_START_BIT];
          pid = {beat.data_byte[4:0], 8'h00};
        end else if (pos == tsavpd_pkg::POS_PID_LOW) begin
          pid[7:0] = beat.data_byte;
        end else if (pos == tsavpd_pkg::POS_FLAGS) begin
          adapt = beat.data_byte[tsavpd_pkg::ADAPT_BIT];
        end else if (pos == tsavpd_pkg::POS_ADAPT_LEN && adapt) begin
          sid_pos = tsavpd_pkg::ADAPT_SID_BASE + {1'b0, beat.data_byte};
        end
        if (pos >= tsavpd_pkg::POS_ADAPT_LEN && {1'b0, pos} == sid_pos && unit_start &&
            !(video_seen && audio_seen)) begin
          classify(beat.data_byte);
        end
        if (pos >= PKT_BYTES - 1) begin
          framing = 1'b0;
        end
      end
      if (beat.end_of_buffer) begin
        r.video_pid    = video_seen ? video_pid : '0;
        r.video_found  = video_seen;
        r.audio_pid    = audio_seen ? audio_pid : '0;
        r.audio_found  = audio_seen;
        r.audio_is_ac3 = audio_seen ? ac3 : 1'b0;
        expected_results.push_back(r);
        clear_parser();
      end
    endfunction

    function string show(tsavpd_pkg::result_t r);
      return $sformatf("video %0d/%0d audio %0d/%0d ac3 %0d", r.video_found, r.video_pid,
                       r.audio_found, r.audio_pid, r.audio_is_ac3);
    endfunction

    function void flag(string msg);
      errors++;
      if (reported < 10) begin
        $display("MISMATCH: %s", msg);
        reported++;
      end
    endfunction

    function void check_result(tsavpd_pkg::result_t got);
      tsavpd_pkg::result_t want;
      if (expected_results.size() == 0) begin
        flag({"result with nothing expected: ", show(got)});
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.video_found) video_hits++;
      if (want.audio_found) audio_hits++;
      if (want.audio_is_ac3) ac3_hits++;
      if ((got.video_pid !== want.video_pid) || (got.video_found !== want.video_found) ||
          (got.audio_pid !== want.audio_pid) || (got.audio_found !== want.audio_found) ||
          (got.audio_is_ac3 !== want.audio_is_ac3)) begin
        flag({"expected ", show(want), ", got ", show(got)});
      end
    endfunction

    function void check_drained();
      while (expected_results.size() != 0) begin
        flag({"result never arrived: ", show(expected_results.pop_front())});
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   byte_valid;
  logic                   byte_stall;
  tsavpd_pkg::byte_beat_t byte_data;
  logic                   result_valid;
  logic                   result_stall;
  tsavpd_pkg::result_t    result_data;

  pid_scoreboard sb;
  logic [7:0]    stream_bytes[$];
  bit            idle_on = 1'b1;
  bit            hold_requested = 1'b0;
  bit            hold_done = 1'b0;
  int            bytes_sent = 0;
  int            buffers_sent = 0;
  int            input_held = 0;

  ts_av_pid_detector_unit #(
    .PACKET_BYTES(PKT_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result_data);
      if (byte_valid && byte_stall) input_held++;
    end
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requested && !hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] pick_stream_id();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range(tsavpd_pkg::VIDEO_SID_LOW, tsavpd_pkg::VIDEO_SID_HIGH));
      2, 3: return 8'($urandom_range(tsavpd_pkg::AUDIO_SID_LOW, tsavpd_pkg::AUDIO_SID_HIGH));
      4: return tsavpd_pkg::PRIVATE_1_SID;
      5: begin
        case ($urandom_range(0, 3))
          0: return tsavpd_pkg::VIDEO_SID_LOW;
          1: return tsavpd_pkg::VIDEO_SID_HIGH;
          2: return tsavpd_pkg::AUDIO_SID_LOW;
          default: return tsavpd_pkg::AUDIO_SID_HIGH;
        endcase
      end
      6: begin
        case ($urandom_range(0, 3))
          0: return tsavpd_pkg::PRIVATE_1_SID - 8'd1;
          1: return tsavpd_pkg::PRIVATE_1_SID + 8'd1;
          2: return tsavpd_pkg::AUDIO_SID_LOW - 8'd1;
          default: return tsavpd_pkg::VIDEO_SID_HIGH + 8'd1;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void append_junk(int count, bit clean);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (clean && b == tsavpd_pkg::SYNC_BYTE) b = ~b;
      stream_bytes.push_back(b);
    end
  endfunction

  function automatic void append_packet(bit cut);
    logic [7:0] pkt[PKT_BYTES];
    int         sid_at;
    int         keep;
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    pkt[0] = tsavpd_pkg::SYNC_BYTE;
    pkt[1][tsavpd_pkg::UNIT_START_BIT] = ($urandom_range(0, 9) < 8);
    pkt[3][tsavpd_pkg::ADAPT_BIT] = ($urandom_range(0, 9) < 3);
    sid_at = tsavpd_pkg::DEFAULT_SID_POS;
    if (pkt[3][tsavpd_pkg::ADAPT_BIT]) begin
      pkt[4] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(176, 255))
                                           : 8'($urandom_range(0, 40));
      sid_at = tsavpd_pkg::ADAPT_SID_BASE + pkt[4];
    end
    if (sid_at < PKT_BYTES) pkt[sid_at] = pick_stream_id();
    keep = cut ? $urandom_range(1, (sid_at + 2 < PKT_BYTES) ? sid_at + 2 : PKT_BYTES)
               : PKT_BYTES;
    for (int i = 0; i < keep; i++) stream_bytes.push_back(pkt[i]);
  endfunction

  task automatic send_beat(input logic [7:0] value, input logic last);
    tsavpd_pkg::byte_beat_t beat;
    beat.data_byte = value;
    beat.end_of_buffer = last;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= beat;
    do @(posedge clk); while (byte_stall);
    sb.note_beat(beat);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_beat(stream_bytes[i], i == stream_bytes.size() - 1);
    buffers_sent++;
    stream_bytes.delete();
  endtask

  task automatic send_random_buffer();
    int sel;
    int count;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      append_junk($urandom_range(1, 30), 1'b0);
    end else if (sel < 16) begin
      append_junk($urandom_range(0, 2), 1'b1);
      append_packet(1'b1);
    end else begin
      count = $urandom_range(2, 3);
      for (int k = 0; k < count; k++) begin
        append_junk($urandom_range(0, 3), 1'b1);
        append_packet(k == count - 1 && $urandom_range(0, 1) == 1);
      end
    end
    send_stream();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stream_bytes = '{8'h00};
    send_stream();
    stream_bytes = '{8'hFF};
    send_stream();
    stream_bytes = '{tsavpd_pkg::SYNC_BYTE};
    send_stream();
    stream_bytes = '{tsavpd_pkg::SYNC_BYTE, 8'h5F, 8'hFF, 8'h10, 8'h00, 8'h00, 8'h00,
                     tsavpd_pkg::VIDEO_SID_LOW};
    send_stream();
    stream_bytes = '{tsavpd_pkg::SYNC_BYTE, 8'h40, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00,
                     tsavpd_pkg::PRIVATE_1_SID};
    send_stream();
    stream_bytes = '{tsavpd_pkg::SYNC_BYTE, 8'h41, 8'h23, 8'h30, 8'hFF};
    send_stream();

    while (bytes_sent < 900) send_random_buffer();

    hold_requested = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) append_packet(1'b1);
      else append_junk($urandom_range(1, 3), 1'b0);
      send_stream();
    end

    while (bytes_sent < 1100 || buffers_sent < 44) send_random_buffer();

    idle_on = 1'b0;
    repeat (8) send_random_buffer();
    byte_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();

    $display("Sent %0d bytes in %0d buffers; checked %0d results", bytes_sent, buffers_sent,
             sb.checked);
    $display("(%0d video, %0d audio, %0d AC3); input held off %0d cycles; %0d mismatches.",
             sb.video_hits, sb.audio_hits, sb.ac3_hits, input_held, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
sv/tsavpd_pkg.sv
sv/tsavpd_out_buf.sv
sv/ts_av_pid_detector_unit.sv
dv/ts_av_pid_detector_unit_test.sv
